// File: design/scc_pkg.sv
`timescale 1ns / 1ps
package scc_pkg;

  localparam int ADC_W  = 12;
  localparam int VAL_W  = 10;
  localparam int RES_W  = 16;
  localparam int TBL_AW = 6;
  localparam int TBL_DEPTH = 64;

  localparam logic [ADC_W-1:0] ADC_FULL = 12'd4095;
  localparam logic [VAL_W-1:0] DUTY_MAX = 10'd999;
  localparam logic [VAL_W-1:0] PCT_MAX  = 10'd100;

  // light divider: numerator up to 4095*100 + 4094, quotient at most 100
  localparam int DIV_NUM_W = 19;
  localparam int DIV_Q_W   = 7;
  localparam int DIV_STEP_W = 3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TABLE  = 1'b1;

  localparam logic [1:0] CH_POT   = 2'd0;
  localparam logic [1:0] CH_THERM = 2'd1;
  localparam logic [1:0] CH_LIGHT = 2'd2;

  localparam logic [1:0] CFG_BRIGHT  = 2'd0;
  localparam logic [1:0] CFG_DARK    = 2'd1;
  localparam logic [1:0] CFG_DIVIDER = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POT_MUL,
    ST_POT_DIV,
    ST_SCAN,
    ST_LIGHT,
    ST_DIV,
    ST_WIN_RD,
    ST_WIN_UPD,
    ST_MEAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [ADC_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: design/scc_ram.sv
`timescale 1ns / 1ps
module scc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/scc_div.sv
`timescale 1ns / 1ps
module scc_div
  import scc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_NUM_W-1:0]  rem;
  logic [ADC_W-1:0]      den;
  logic [DIV_Q_W-1:0]    quo;
  logic [DIV_STEP_W-1:0] step;
  logic                  busy;
  logic                  done;
  logic [DIV_NUM_W-1:0]  trial;

  // restoring division, one quotient bit per cycle, MSB first
  assign trial = DIV_NUM_W'(den) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == '0);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.dividend;
      den  <= req.divisor;
      quo  <= '0;
      step <= DIV_STEP_W'(DIV_Q_W - 1);
    end else if (busy) begin
      if (rem >= trial) begin
        rem       <= rem - trial;
        quo[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: design/sensor_channel_conditioner.sv
`timescale 1ns / 1ps
// Sensor channel conditioner.
// Input channel (in_valid/in_ready): operation 0 carries an ADC sample for
// channel 0 (pot), 1 (thermistor) or 2 (light); operation 1 writes one
// thermistor resistance table entry and returns nothing. Samples on an
// unknown channel are dropped without a result.
// Output channel (out_valid/out_ready): channel and the 8-sample window mean.
// Config channel (cfg_valid/cfg_ready, always ready): bright limit, dark
// limit, divider resistance; write only while the block is idle.
// One request at a time. A pot sample passes a multiply and a divide state,
// a light sample waits on the iterative divider (not used unless the dark
// limit exceeds the bright limit), and a thermistor sample waits on the
// one-entry-per-cycle scan of the table memory.
// Reset clears the windows (per-entry valid bits), pointers and sums, and
// loads default limits and divider; the table is undefined until written.
// The result sits in an output register; the next request is accepted while
// it waits, but its own result waits until the receiver takes the first.
module sensor_channel_conditioner
  import scc_pkg::*;
#(
  parameter int WINDOW_LEN = 8,
  parameter int TABLE_LEN  = 61,
  parameter int CHANNELS   = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [RES_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [1:0]        channel,
  input  logic [ADC_W-1:0]  adc_value,
  input  logic [TBL_AW-1:0] table_index,
  input  logic [RES_W-1:0]  table_resistance,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_channel,
  output logic [VAL_W-1:0]  filtered_value
);

  localparam int WIN_DEPTH = CHANNELS * WINDOW_LEN;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int PTR_W     = $clog2(WINDOW_LEN);
  localparam int CH_IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W     = $clog2(1000 * WINDOW_LEN);
  // floor(sum / WINDOW_LEN) as an exact reciprocal multiply
  localparam int MEAN_SHIFT = SUM_W + $clog2(WINDOW_LEN) + 1;
  localparam int MUL_W      = MEAN_SHIFT;
  localparam logic [MUL_W-1:0] MEAN_MUL =
    MUL_W'(((64'd1 << MEAN_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);
  localparam int CNT_W = TBL_AW + 1;
  localparam int PROD_W = RES_W + ADC_W;

  state_t state, state_next;

  logic [ADC_W-1:0] bright_limit;
  logic [ADC_W-1:0] dark_limit;
  logic [RES_W-1:0] divider_resistance;

  logic [1:0]       ch_q;
  logic [ADC_W-1:0] adc_q;
  logic [VAL_W-1:0] value;
  logic [21:0]      work;
  logic [22:0]      pot_sum;

  logic [CNT_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  therm_cnt;
  logic              rd_pend;
  logic              scan_issue;
  logic [ADC_W-1:0]  lhs;
  logic [PROD_W-1:0] rhs;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_addr;
  logic [RES_W-1:0]  tbl_rdata;

  logic [ADC_W-1:0]     a_hi, a_clamp, span;
  logic [DIV_NUM_W-1:0] light_num;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CH_IW-1:0]  ch_idx;
  logic [PTR_W-1:0]  ptrs [CHANNELS];
  logic [SUM_W-1:0]  sums [CHANNELS];
  logic [WIN_DEPTH-1:0] win_vld;
  logic [WIN_AW-1:0] win_addr;
  logic              win_we;
  logic [VAL_W-1:0]  win_rdata;
  logic [VAL_W-1:0]  win_old;
  logic [SUM_W+MUL_W-1:0] mean_prod;

  logic in_acc;
  logic ch_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign ch_ok     = (channel == CH_POT || channel == CH_THERM || channel == CH_LIGHT)
                     && (int'(channel) < CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_limit       <= 12'd2800;
      dark_limit         <= 12'd3800;
      divider_resistance <= 16'd2560;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BRIGHT:  bright_limit       <= cfg_data[ADC_W-1:0];
        CFG_DARK:    dark_limit         <= cfg_data[ADC_W-1:0];
        CFG_DIVIDER: divider_resistance <= cfg_data;
        default: ;
      endcase
    end
  end

  // thermistor table
  assign tbl_we   = in_acc && (operation == OP_TABLE) && (int'(table_index) < TABLE_LEN);
  assign tbl_addr = tbl_we ? table_index : scan_idx[TBL_AW-1:0];
  assign scan_issue = (state == ST_SCAN) && (scan_idx < CNT_W'(TABLE_LEN));

  scc_ram #(.WIDTH(RES_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .addr  (tbl_addr),
    .wdata (table_resistance),
    .rdata (tbl_rdata)
  );

  // pot: floor(x / 4095) = (x + (x >> 12) + 1) >> 12 for x < 2^24 - 1
  assign pot_sum = {1'b0, work} + 23'(work >> 12) + 23'd1;

  // light
  assign a_hi      = (adc_q > dark_limit) ? dark_limit : adc_q;
  assign a_clamp   = (a_hi < bright_limit) ? bright_limit : a_hi;
  assign span      = dark_limit - bright_limit;
  assign light_num = DIV_NUM_W'((a_clamp - bright_limit) * 7'd100)
                     + DIV_NUM_W'(span) - DIV_NUM_W'(1);

  assign div_req.start    = (state == ST_LIGHT) && (dark_limit > bright_limit);
  assign div_req.dividend = light_num;
  assign div_req.divisor  = span;

  scc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // window store
  assign ch_idx   = CH_IW'(ch_q);
  assign win_addr = WIN_AW'(int'(ch_idx) * WINDOW_LEN) + WIN_AW'(ptrs[ch_idx]);
  assign win_we   = (state == ST_WIN_UPD);
  assign win_old  = win_vld[win_addr] ? win_rdata : '0;

  scc_ram #(.WIDTH(VAL_W), .DEPTH(WIN_DEPTH)) u_win (
    .clk   (clk),
    .we    (win_we),
    .addr  (win_addr),
    .wdata (value),
    .rdata (win_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && operation == OP_SAMPLE && ch_ok) begin
          case (channel)
            CH_POT:   state_next = ST_POT_MUL;
            CH_THERM: state_next = ST_SCAN;
            default:  state_next = ST_LIGHT;
          endcase
        end
      end
      ST_POT_MUL: state_next = ST_POT_DIV;
      ST_POT_DIV: state_next = ST_WIN_RD;
      ST_SCAN: begin
        if (!scan_issue && !rd_pend) begin
          state_next = ST_WIN_RD;
        end
      end
      ST_LIGHT:   state_next = div_req.start ? ST_DIV : ST_WIN_RD;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_WIN_RD;
        end
      end
      ST_WIN_RD:  state_next = ST_WIN_UPD;
      ST_WIN_UPD: state_next = ST_MEAN;
      ST_MEAN:    state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      win_vld   <= '0;
      rd_pend   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        ptrs[i] <= '0;
        sums[i] <= '0;
      end
    end else begin
      state   <= state_next;
      rd_pend <= scan_issue;
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_WIN_UPD) begin
        win_vld[win_addr] <= 1'b1;
        sums[ch_idx] <= sums[ch_idx] - SUM_W'(win_old) + SUM_W'(value);
        ptrs[ch_idx] <= (ptrs[ch_idx] == PTR_W'(WINDOW_LEN - 1)) ? '0
                        : ptrs[ch_idx] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          ch_q      <= channel;
          adc_q     <= adc_value;
          scan_idx  <= '0;
          therm_cnt <= '0;
          lhs       <= ADC_FULL - adc_value;
          rhs       <= divider_resistance * adc_value;
        end
      end
      ST_POT_MUL: work  <= 22'((ADC_FULL - adc_q) * DUTY_MAX);
      ST_POT_DIV: value <= VAL_W'(pot_sum >> 12);
      ST_SCAN: begin
        if (scan_issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (rd_pend && (tbl_rdata * lhs >= rhs)) begin
          therm_cnt <= therm_cnt + 1'b1;
        end
        if (!scan_issue && !rd_pend) begin
          value <= (therm_cnt != '0) ? VAL_W'(therm_cnt - 1'b1) : '0;
        end
      end
      ST_LIGHT: begin
        if (!div_req.start) begin
          value <= PCT_MAX;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          value <= PCT_MAX - VAL_W'(div_rsp.quotient);
        end
      end
      ST_MEAN: mean_prod <= sums[ch_idx] * MEAN_MUL;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_channel    <= ch_q;
          filtered_value <= VAL_W'(mean_prod >> MEAN_SHIFT);
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> therm_cnt <= CNT_W'(TABLE_LEN))
    else $error("thermistor count exceeds table length");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result raised outside output state");

  a_scan_idle: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == ST_SCAN)
    else $error("table read pending outside scan");

  a_tbl_write: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> state == ST_IDLE && !scan_issue)
    else $error("table write collides with scan");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import scc_pkg::*;

  localparam logic [1:0] CH_NONE = 2'd3;
  localparam int N_TBL = 61;
  localparam int WIN = 8;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = 100;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = CFG_BRIGHT;
  logic [RES_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             operation = OP_SAMPLE;
  logic [1:0]       channel = CH_POT;
  logic [ADC_W-1:0] adc_value = '0;
  logic [TBL_AW-1:0] table_index = '0;
  logic [RES_W-1:0] table_resistance = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_channel;
  logic [VAL_W-1:0] filtered_value;

  sensor_channel_conditioner dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct {
    logic             op;
    logic [1:0]       ch;
    logic [ADC_W-1:0] adc;
    logic [TBL_AW-1:0] idx;
    logic [RES_W-1:0] res;
    bit               typed;
    logic [VAL_W-1:0] typed_val;
  } request_t;

  typedef struct {
    logic [1:0]       ch;
    logic [VAL_W-1:0] val;
  } average_t;

  // predictor state
  logic [ADC_W-1:0] m_bright;
  logic [ADC_W-1:0] m_dark;
  logic [RES_W-1:0] m_divider;
  logic [VAL_W-1:0] m_win[3][WIN];
  logic [RES_W-1:0] m_table[TBL_DEPTH];

  average_t pending_avg[$];
  request_t directed_rows[$];
  int errors = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cfg = 0;
  int burst_left = 0;
  bit idling_on = 1'b1;
  int idle_cycles = 0;

  function automatic logic [VAL_W-1:0] channel_value(logic [1:0] ch, logic [ADC_W-1:0] a);
    longint unsigned lhs, rhs, span, num, lo, hi, av;
    int count;
    lhs = 4095 - a;
    rhs = longint'(m_divider) * a;
    count = 0;
    lo = m_bright;
    hi = m_dark;
    av = a;
    if (ch == CH_POT) return VAL_W'(((4095 - av) * 999) / 4095);
    if (ch == CH_THERM) begin
      for (int i = 0; i < N_TBL; i++)
        if (longint'(m_table[i]) * lhs >= rhs) count++;
      return (count > 0) ? VAL_W'(count - 1) : '0;
    end
    if (hi <= lo) return VAL_W'(100);
    if (av > hi) av = hi;
    if (av < lo) av = lo;
    span = hi - lo;
    num = (av - lo) * 100;
    return VAL_W'(100 - (num + span - 1) / span);
  endfunction

  // returns 1 when the request produces an average
  function automatic bit update_model(request_t r, output average_t avg);
    int sum;
    sum = 0;
    avg.ch = r.ch;
    avg.val = '0;
    if (r.op == OP_TABLE) begin
      if (r.idx < N_TBL) m_table[r.idx] = r.res;
      return 1'b0;
    end
    if (r.ch == CH_NONE) return 1'b0;
    for (int i = 0; i < WIN - 1; i++) m_win[r.ch][i] = m_win[r.ch][i+1];
    m_win[r.ch][WIN-1] = channel_value(r.ch, r.adc);
    for (int i = 0; i < WIN; i++) sum += m_win[r.ch][i];
    avg.val = VAL_W'(sum / WIN);
    return 1'b1;
  endfunction

  task automatic send(request_t r);
    average_t avg;
    int gap;
    gap = 0;
    if (idling_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= r.op;
    channel <= r.ch;
    adc_value <= r.adc;
    table_index <= r.idx;
    table_resistance <= r.res;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (update_model(r, avg)) begin
      if (r.typed) avg.val = r.typed_val;
      pending_avg.push_back(avg);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_avg.size() != 0) @(posedge clk);
    // table writes and dropped samples leave no result to wait for
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [RES_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      CFG_BRIGHT: m_bright = data[ADC_W-1:0];
      CFG_DARK: m_dark = data[ADC_W-1:0];
      default: m_divider = data;
    endcase
  endtask

  function automatic request_t sample_req(logic [1:0] ch, logic [ADC_W-1:0] a);
    request_t r;
    r.op = OP_SAMPLE;
    r.ch = ch;
    r.adc = a;
    r.idx = TBL_AW'($urandom);
    r.res = RES_W'($urandom);
    r.typed = 1'b0;
    r.typed_val = '0;
    return r;
  endfunction

  function automatic request_t table_req(logic [TBL_AW-1:0] i, logic [RES_W-1:0] v);
    request_t r;
    r = sample_req(2'($urandom), ADC_W'($urandom));
    r.op = OP_TABLE;
    r.idx = i;
    r.res = v;
    return r;
  endfunction

  function automatic request_t known_req(logic [1:0] ch, logic [ADC_W-1:0] a,
                                         logic [VAL_W-1:0] v);
    request_t r;
    r = sample_req(ch, a);
    r.typed = 1'b1;
    r.typed_val = v;
    return r;
  endfunction

  function automatic request_t random_req();
    int pick;
    logic [ADC_W-1:0] a;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: a = '0;
      1: a = '1;
      2: a = ADC_W'(m_bright + $urandom_range(0, 3) - 1);
      3: a = ADC_W'(m_dark + $urandom_range(0, 3) - 1);
      default: a = ADC_W'($urandom);
    endcase
    if (pick < 20) return table_req(TBL_AW'($urandom_range(0, 63)), RES_W'($urandom));
    if (pick < 25) return sample_req(CH_NONE, a);
    return sample_req(2'($urandom_range(0, 2)), a);
  endfunction

  // receiver stall pattern: always ready, random ready or sparse ready, re-picked at random
  int rx_cycle = 0;
  int rx_mode = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_mode <= $urandom_range(0, 2);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (rx_cycle % 4 == 0);
    endcase
  end

  always @(posedge clk) begin
    average_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_avg.size() == 0) begin
        errors++;
        $display("unexpected result: ch=%0d val=%0d", out_channel, filtered_value);
      end else begin
        want = pending_avg.pop_front();
        if (out_channel !== want.ch || filtered_value !== want.val) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ch=%0d val=%0d, got ch=%0d val=%0d",
                     want.ch, want.val, out_channel, filtered_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("[sensor_channel_conditioner] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [RES_W-1:0] level;
    m_bright = 12'd2800;
    m_dark = 12'd3800;
    m_divider = 16'd2560;
    for (int c = 0; c < 3; c++)
      for (int i = 0; i < WIN; i++) m_win[c][i] = '0;
    for (int i = 0; i < TBL_DEPTH; i++) m_table[i] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // samples from reset state, before the table is touched
    directed_rows.push_back(known_req(CH_POT, 12'd0, 10'd124));
    directed_rows.push_back(known_req(CH_POT, 12'd4095, 10'd124));
    directed_rows.push_back(sample_req(CH_POT, 12'd2048));
    directed_rows.push_back(known_req(CH_LIGHT, 12'd0, 10'd12));
    directed_rows.push_back(known_req(CH_LIGHT, 12'd4095, 10'd12));
    directed_rows.push_back(sample_req(CH_LIGHT, 12'd3300));
    directed_rows.push_back(sample_req(CH_NONE, 12'd77));
    directed_rows.push_back(table_req(6'd61, 16'hFFFF));
    directed_rows.push_back(table_req(6'd63, 16'h0000));
    foreach (directed_rows[i]) send(directed_rows[i]);

    // load a descending table before any thermistor sample
    level = 16'hFFFF;
    for (int i = 0; i < N_TBL; i++) begin
      send(table_req(TBL_AW'(i), (i == N_TBL - 1) ? 16'h0000 : level));
      level = (level > 16'd2100) ? RES_W'(level - $urandom_range(0, 2100)) : 16'd0;
    end
    directed_rows.delete();
    directed_rows.push_back(known_req(CH_THERM, 12'd4095, 10'd0));
    directed_rows.push_back(known_req(CH_THERM, 12'd0, 10'd7));
    directed_rows.push_back(sample_req(CH_THERM, 12'd2000));
    directed_rows.push_back(sample_req(CH_THERM, 12'd1));
    foreach (directed_rows[i]) send(directed_rows[i]);
    drain();

    // unordered limits, zero divider
    write_reg(CFG_BRIGHT, 16'd4095);
    write_reg(CFG_DARK, 16'd0);
    write_reg(CFG_DIVIDER, 16'd0);
    send(sample_req(CH_LIGHT, 12'd2000));
    send(sample_req(CH_THERM, 12'd4095));
    send(sample_req(CH_THERM, 12'd1234));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_BRIGHT, 16'd0);
          write_reg(CFG_DARK, 16'd4095);
          write_reg(CFG_DIVIDER, 16'hFFFF);
        end
        1: begin
          write_reg(CFG_BRIGHT, 16'd2800);
          write_reg(CFG_DARK, 16'd3800);
          write_reg(CFG_DIVIDER, 16'd2560);
        end
        2: begin
          write_reg(CFG_BRIGHT, 16'd2000);
          write_reg(CFG_DARK, 16'd2001);
        end
        default: begin
          write_reg(CFG_BRIGHT, RES_W'($urandom_range(0, 4095)));
          write_reg(CFG_DARK, RES_W'($urandom_range(0, 4095)));
          write_reg(CFG_DIVIDER, RES_W'($urandom));
        end
      endcase
      idling_on = (phase != 1);
      burst_left = 0;
      repeat (262) send(random_req());
      drain();
    end

    $display("covered %0d requests, %0d averages, %0d register writes",
             n_items, n_results, n_cfg);
    $display("%0d failures, %0d averages never seen", errors, pending_avg.size());
    if (errors == 0 && pending_avg.size() == 0) begin
      $display("[sensor_channel_conditioner] OK");
    end else begin
      $display("[sensor_channel_conditioner] ERROR");
    end
    $finish;
  end

endmodule

// File: sensor_channel_conditioner.f
design/scc_pkg.sv
design/scc_ram.sv
design/scc_div.sv
design/sensor_channel_conditioner.sv
test/tb_top.sv
